// ===== rtl/core/histeq_pkg.sv =====
// histeq_pkg: shared constants, types and codes of the histogram equaliser
// used by histeq_div, histogram_equalizer_top and the bench; no dependencies
package histeq_pkg;

  // sizing
  localparam int unsigned MAX_PIXELS_LOG2 = 20;
  localparam int unsigned GRAY_LEVELS     = 256;
  localparam int unsigned PIX_W           = 8;
  localparam int unsigned LEVEL_W         = $clog2(GRAY_LEVELS);
  localparam int unsigned OUT_W           = 8;
  localparam int unsigned COUNT_W         = MAX_PIXELS_LOG2 + 1;
  localparam int unsigned PROD_W          = COUNT_W + OUT_W;
  localparam int unsigned QSTEP_W         = $clog2(OUT_W);

  // pixel capacity of the histogram, total never goes past it
  localparam logic [COUNT_W-1:0] CAPACITY = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [OUT_W-1:0]   level_t;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_BUILD = 2'd2,
    OP_MAP   = 2'd3
  } op_e;

  // bin walk sequencer
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_ACC  = 4'b0100,
    S_DIV  = 4'b1000
  } build_state_e;

  // request to the iterative divider
  typedef struct packed {
    logic                start;
    logic [PROD_W-1:0]   dividend;
    logic [COUNT_W-1:0]  divisor;
  } div_req_t;

endpackage

// ===== rtl/core/histeq_ram.sv =====
// histeq_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies; read returns the old contents on a same-address write
module histeq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/histeq_div.sv =====
// histeq_div: restoring divider, one quotient bit per cycle, 8-bit quotient
// depends on histeq_pkg; dividend must be below 2^OUT_W times the divisor
module histeq_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  histeq_pkg::div_req_t req_i,
  output logic                 done_o,
  output histeq_pkg::level_t   quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [histeq_pkg::QSTEP_W-1:0]   cnt_q, cnt_d;
  logic [histeq_pkg::PROD_W-1:0]    rem_q, rem_d;
  histeq_pkg::count_t               dvs_q, dvs_d;
  histeq_pkg::level_t               quo_q, quo_d;
  logic [histeq_pkg::PROD_W-1:0]    dvs_shift;
  logic [histeq_pkg::PROD_W:0]      trial;
  logic                             fits;

  // trial subtraction of the divisor at the current bit weight
  assign dvs_shift = histeq_pkg::PROD_W'(dvs_q) << cnt_q;
  assign trial     = {1'b0, rem_q} - {1'b0, dvs_shift};
  assign fits      = ~trial[histeq_pkg::PROD_W];

  // next state of the iteration
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = histeq_pkg::QSTEP_W'(histeq_pkg::OUT_W - 1);
      rem_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = trial[histeq_pkg::PROD_W-1:0];
      end
      quo_d = {quo_q[histeq_pkg::OUT_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/histogram_equalizer_top.sv =====
// histogram_equalizer_top: gray-level histogram equaliser, top level
// depends on histeq_pkg, histeq_ram (bins and level map) and histeq_div
//
// A transaction is taken on a rising edge with start high and busy low. Count
// and map transactions are taken one per cycle while busy is low; a map
// transaction gives its equalised level on mapped_pixel_o with mapped_valid_o
// high for exactly one cycle, in the cycle after it was taken, and the receiver
// cannot stall it. Clear drops the per-bin valid flags at once, so no sweep of
// the bin memory is needed, neither after reset nor after clear. Build walks
// all 256 bins, each through a bin memory read, an accumulate step and the
// one-bit-per-cycle divider, and busy stays high until the last bin is done.
// The level map is undefined until the first build.
module histogram_equalizer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic [1:0]                        op_i,
  input  logic [histeq_pkg::PIX_W-1:0]      pixel_value_i,
  output logic                              busy,
  output logic                              mapped_valid_o,
  output logic [histeq_pkg::OUT_W-1:0]      mapped_pixel_o
);

  histeq_pkg::op_e                    op;
  logic                               accept;
  logic                               clr_acc, cnt_acc, bld_acc, map_acc;

  histeq_pkg::build_state_e           state_q, state_d;
  logic [histeq_pkg::LEVEL_W-1:0]     g_q, g_d;
  histeq_pkg::count_t                 run_q, run_d;
  histeq_pkg::count_t                 total_q, total_d;
  logic [histeq_pkg::GRAY_LEVELS-1:0] valid_q, valid_d;

  logic                               cnt_s1_q;
  logic [histeq_pkg::LEVEL_W-1:0]     cnt_px_q;
  logic                               fwd_vld_q;
  logic [histeq_pkg::LEVEL_W-1:0]     fwd_addr_q;
  histeq_pkg::count_t                 fwd_data_q;
  logic                               map_s1_q;

  logic [histeq_pkg::LEVEL_W-1:0]     bin_raddr;
  histeq_pkg::count_t                 bin_rdata;
  histeq_pkg::count_t                 bin_base;
  histeq_pkg::count_t                 bin_inc;
  histeq_pkg::count_t                 bin_walk;
  histeq_pkg::count_t                 run_sum;

  histeq_pkg::div_req_t               div_req;
  logic                               div_done;
  histeq_pkg::level_t                 div_quo;
  logic                               map_we;
  histeq_pkg::level_t                 map_wdata;
  histeq_pkg::level_t                 map_rdata;

  // transaction decode
  assign op      = histeq_pkg::op_e'(op_i);
  assign busy    = (state_q != histeq_pkg::S_IDLE);
  assign accept  = start & ~busy;
  assign clr_acc = accept & (op == histeq_pkg::OP_CLEAR);
  assign cnt_acc = accept & (op == histeq_pkg::OP_COUNT) & (total_q != histeq_pkg::CAPACITY);
  assign bld_acc = accept & (op == histeq_pkg::OP_BUILD);
  assign map_acc = accept & (op == histeq_pkg::OP_MAP);

  // bin memory: read for count or bin walk, write back incremented count
  assign bin_raddr = (state_q == histeq_pkg::S_READ) ? g_q
                                                     : pixel_value_i[histeq_pkg::LEVEL_W-1:0];

  histeq_ram #(
    .Width (histeq_pkg::COUNT_W),
    .Depth (histeq_pkg::GRAY_LEVELS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_s1_q),
    .waddr_i (cnt_px_q),
    .wdata_i (bin_inc),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  // read-modify-write with forwarding of the write from the previous cycle
  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == cnt_px_q)) begin
      bin_base = fwd_data_q;
    end else if (valid_q[cnt_px_q]) begin
      bin_base = bin_rdata;
    end else begin
      bin_base = '0;
    end
  end
  assign bin_inc = bin_base + 1'b1;

  // bin valid flags and pixel total
  always_comb begin
    valid_d = valid_q;
    total_d = total_q;
    if (clr_acc) begin
      valid_d = '0;
      total_d = '0;
    end else begin
      if (cnt_s1_q) begin
        valid_d[cnt_px_q] = 1'b1;
      end
      if (cnt_acc) begin
        total_d = total_q + 1'b1;
      end
    end
  end

  // bin walk accumulation and divider request
  assign bin_walk = valid_q[g_q] ? bin_rdata : '0;
  assign run_sum  = run_q + bin_walk;

  assign div_req.start    = (state_q == histeq_pkg::S_ACC);
  assign div_req.dividend = {run_sum, histeq_pkg::OUT_W'(0)} - histeq_pkg::PROD_W'(run_sum);
  assign div_req.divisor  = total_q;

  histeq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // build sequencer
  always_comb begin
    state_d = state_q;
    g_d     = g_q;
    run_d   = run_q;
    unique case (state_q)
      histeq_pkg::S_IDLE: begin
        if (bld_acc) begin
          state_d = histeq_pkg::S_READ;
          g_d     = '0;
          run_d   = '0;
        end
      end
      histeq_pkg::S_READ: begin
        state_d = histeq_pkg::S_ACC;
      end
      histeq_pkg::S_ACC: begin
        run_d   = run_sum;
        state_d = histeq_pkg::S_DIV;
      end
      histeq_pkg::S_DIV: begin
        if (div_done) begin
          g_d = g_q + 1'b1;
          if (g_q == histeq_pkg::LEVEL_W'(histeq_pkg::GRAY_LEVELS - 1)) begin
            state_d = histeq_pkg::S_IDLE;
          end else begin
            state_d = histeq_pkg::S_READ;
          end
        end
      end
      default: begin
        state_d = histeq_pkg::S_IDLE;
      end
    endcase
  end

  // level map: written by the walk, read by map transactions
  assign map_we    = (state_q == histeq_pkg::S_DIV) & div_done;
  assign map_wdata = (total_q == '0) ? '0 : div_quo;

  histeq_ram #(
    .Width (histeq_pkg::OUT_W),
    .Depth (histeq_pkg::GRAY_LEVELS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (g_q),
    .wdata_i (map_wdata),
    .raddr_i (pixel_value_i[histeq_pkg::LEVEL_W-1:0]),
    .rdata_o (map_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= histeq_pkg::S_IDLE;
      g_q       <= '0;
      run_q     <= '0;
      total_q   <= '0;
      valid_q   <= '0;
      cnt_s1_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      map_s1_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      g_q       <= g_d;
      run_q     <= run_d;
      total_q   <= total_d;
      valid_q   <= valid_d;
      cnt_s1_q  <= cnt_acc;
      fwd_vld_q <= cnt_s1_q & ~clr_acc;
      map_s1_q  <= map_acc;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cnt_px_q   <= pixel_value_i[histeq_pkg::LEVEL_W-1:0];
    fwd_addr_q <= cnt_px_q;
    fwd_data_q <= bin_inc;
  end

  // result
  assign mapped_valid_o = map_s1_q;
  assign mapped_pixel_o = map_rdata;

  // checks
  a_build_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bld_acc |=> busy)
    else $error("build transaction did not start the bin walk");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mapped_valid_o |-> $past(map_acc))
    else $error("result strobe without a preceding map transaction");

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= histeq_pkg::CAPACITY)
    else $error("pixel total beyond capacity");

  a_no_count_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_s1_q |-> (state_q == histeq_pkg::S_IDLE))
    else $error("bin write overlaps the bin walk");

endmodule

// ===== bench/histeq_checker.sv =====
// histeq_checker: watches the transaction and result channels of the histogram
// equaliser, predicts each mapped level and compares; depends on histeq_pkg
module histeq_checker
  import histeq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [1:0]          op_i,
  input  logic [PIX_W-1:0]    pixel_i,
  input  logic                valid_i,
  input  level_t              level_i,
  output int unsigned         outstanding_o,
  output int unsigned         fail_count_o
);

  // predicted histogram, pixel total and level lookup
  count_t      bins_q [GRAY_LEVELS];
  count_t      total_q;
  level_t      lut_q [GRAY_LEVELS];
  level_t      levels_due [$];
  level_t      want;
  int unsigned errors;

  // cumulative walk over the bins, floor(255 * running / total)
  task automatic rebuild_lut();
    longint unsigned running = 0;
    longint unsigned scaled;
    for (int g = 0; g < GRAY_LEVELS; g++) begin
      running += bins_q[g];
      if (total_q == '0) begin
        lut_q[g] = '0;
      end else begin
        scaled = (longint'(255) * running) / total_q;
        if (scaled > 255) scaled = 255;
        lut_q[g] = level_t'(scaled);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want_v, got_v);
    errors++;
  endtask

  // result check first, then prediction of the transaction taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bins_q[g]) begin
        bins_q[g] = '0;
        lut_q[g]  = '0;
      end
      total_q = '0;
      levels_due.delete();
      errors = 0;
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      if (valid_i) begin
        if (levels_due.size() == 0) begin
          report_mismatch("mapped_pixel with no map transaction pending", 0,
                          32'(level_i));
        end else begin
          want = levels_due.pop_front();
          if (level_i !== want) report_mismatch("mapped_pixel", 32'(want), 32'(level_i));
        end
      end
      if (start_i && !busy_i) begin
        case (op_e'(op_i))
          OP_CLEAR: begin
            foreach (bins_q[g]) bins_q[g] = '0;
            total_q = '0;
          end
          OP_COUNT: begin
            // counts beyond capacity are dropped
            if (pixel_i < GRAY_LEVELS && total_q < CAPACITY) begin
              bins_q[pixel_i] = bins_q[pixel_i] + 1'b1;
              total_q = total_q + 1'b1;
            end
          end
          OP_BUILD: rebuild_lut();
          OP_MAP: levels_due.push_back(pixel_i < GRAY_LEVELS ? lut_q[pixel_i] : '0);
          default: ;
        endcase
      end
      outstanding_o <= levels_due.size();
      fail_count_o  <= errors;
    end
  end

endmodule

// ===== bench/histogram_equalizer_top_tb.sv =====
// histogram_equalizer_top_tb: directed and random transactions into the
// histogram equaliser; depends on histeq_pkg, histeq_checker and the rtl
module histogram_equalizer_top_tb;
  import histeq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned PHASE_ITEMS = 400;

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             start   = 1'b0;
  op_e              op_q    = OP_CLEAR;
  logic [PIX_W-1:0] pixel_q = '0;
  logic             busy;
  logic             mapped_valid;
  level_t           mapped_pixel;
  int unsigned      outstanding;
  int unsigned      fail_count;
  int unsigned      cycles = 0;
  int unsigned      items_sent = 0;
  bit               levels_ready = 1'b0;

  histogram_equalizer_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .op_i           (op_q),
    .pixel_value_i  (pixel_q),
    .busy           (busy),
    .mapped_valid_o (mapped_valid),
    .mapped_pixel_o (mapped_pixel)
  );

  histeq_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .op_i          (op_q),
    .pixel_i       (pixel_q),
    .valid_i       (mapped_valid),
    .level_i       (mapped_pixel),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run time guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("histogram_equalizer_top_tb NOT OK");
      $finish;
    end
  end

  // present one transaction and hold it until taken
  task automatic send_txn(input op_e op, input logic [PIX_W-1:0] px);
    start   <= 1'b1;
    op_q    <= op;
    pixel_q <= px;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (op == OP_BUILD) levels_ready = 1'b1;
  endtask

  // idle cycles with noise on the payload, pct idle cycles in a hundred
  task automatic sender_gap(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start   <= 1'b0;
      op_q    <= op_e'($urandom_range(3));
      pixel_q <= PIX_W'($urandom);
      @(posedge clk_i);
    end
  endtask

  // hold off until every mapped level is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy) @(posedge clk_i);
  endtask

  // mostly clear / count / build / map runs, some stray transactions
  task automatic random_phase(input int unsigned pct);
    int unsigned      target;
    int unsigned      n_count;
    int unsigned      n_map;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    op_e              stray;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(3) != 0) begin
          sender_gap(pct);
          send_txn(OP_CLEAR, PIX_W'($urandom));
        end
        if ($urandom_range(3) == 0) begin
          lo = '0;
          hi = '1;
        end else begin
          lo = PIX_W'($urandom_range(255));
          hi = PIX_W'($urandom_range(255, lo));
        end
        n_count = ($urandom_range(19) == 0) ? 0 : $urandom_range(48, 1);
        repeat (n_count) begin
          sender_gap(pct);
          send_txn(OP_COUNT, PIX_W'($urandom_range(hi, lo)));
        end
        sender_gap(pct);
        send_txn(OP_BUILD, PIX_W'($urandom));
        n_map = $urandom_range(24, 1);
        repeat (n_map) begin
          sender_gap(pct);
          case ($urandom_range(3))
            0:       send_txn(OP_MAP, 8'd0);
            1:       send_txn(OP_MAP, 8'd255);
            2:       send_txn(OP_MAP, PIX_W'($urandom_range(hi, lo)));
            default: send_txn(OP_MAP, PIX_W'($urandom));
          endcase
        end
      end else begin
        stray = op_e'($urandom_range(3));
        if (stray == OP_MAP && !levels_ready) stray = OP_COUNT;
        sender_gap(pct);
        send_txn(stray, PIX_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty histogram gives an all-zero map
    send_txn(OP_BUILD, 8'd0);
    send_txn(OP_MAP, 8'd0);
    send_txn(OP_MAP, 8'd255);
    send_txn(OP_MAP, 8'd128);
    // four pixels, at the extremes and at 127
    send_txn(OP_COUNT, 8'd0);
    send_txn(OP_COUNT, 8'd255);
    send_txn(OP_COUNT, 8'd255);
    send_txn(OP_COUNT, 8'd127);
    send_txn(OP_BUILD, 8'd0);
    send_txn(OP_MAP, 8'd0);
    send_txn(OP_MAP, 8'd1);
    send_txn(OP_MAP, 8'd127);
    send_txn(OP_MAP, 8'd128);
    send_txn(OP_MAP, 8'd255);
    // clear leaves the level map alone
    send_txn(OP_CLEAR, 8'd0);
    send_txn(OP_MAP, 8'd0);
    send_txn(OP_MAP, 8'd255);
    // single pixel at the top level
    send_txn(OP_COUNT, 8'd255);
    send_txn(OP_BUILD, 8'd255);
    send_txn(OP_MAP, 8'd254);
    send_txn(OP_MAP, 8'd255);
    drain();

    // burst of back-to-back counts at random levels
    send_txn(OP_CLEAR, 8'd0);
    repeat (64) send_txn(OP_COUNT, PIX_W'($urandom));
    send_txn(OP_BUILD, 8'd0);
    send_txn(OP_MAP, 8'd0);
    send_txn(OP_MAP, 8'd255);
    repeat (8) send_txn(OP_MAP, PIX_W'($urandom));
    send_txn(OP_CLEAR, 8'd0);
    drain();

    // random transactions under three sender gap profiles
    random_phase(11);
    drain();
    random_phase(53);
    random_phase(0);

    drain();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("histogram_equalizer_top_tb OK");
    end else begin
      $display("histogram_equalizer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== histogram_equalizer_top.f =====
rtl/core/histeq_pkg.sv
rtl/core/histeq_ram.sv
rtl/core/histeq_div.sv
rtl/core/histogram_equalizer_top.sv
bench/histeq_checker.sv
bench/histogram_equalizer_top_tb.sv
